// ===== design/shaker_sort_by_key_desc_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the shaker sort block
// Concurrent assertion wrappers; they compile to nothing when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef SHAKER_SORT_BY_KEY_DESC_DEFINES_SVH
`define SHAKER_SORT_BY_KEY_DESC_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked outside reset.
`define SHKR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked outside reset.
`define SHKR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SHKR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define SHKR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== design/shkr_pkg.sv =====
// ----------------------------------------------------------------------------
// Shaker sort package
// Shared widths, payload structs and sequencer state type.
// ----------------------------------------------------------------------------
package shkr_pkg;

  // Default capacity of the record store.
  localparam int MAX_ENTRIES_DEF = 64;

  localparam int KEY_W = 8;
  localparam int TAG_W = 6;
  localparam int REC_W = KEY_W + TAG_W;

  // One input transfer.
  typedef struct packed {
    logic [KEY_W-1:0] key_value;
    logic [TAG_W-1:0] record_tag;
    logic             is_last;
  } in_item_t;

  // One result transfer.
  typedef struct packed {
    logic [KEY_W-1:0] sorted_key;
    logic [TAG_W-1:0] sorted_tag;
    logic             end_of_run;
  } out_item_t;

  // One stored record.
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } rec_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_LOAD,
    ST_BPRIME,
    ST_BLOAD,
    ST_BSTEP,
    ST_BEND,
    ST_FSTEP,
    ST_FEND,
    ST_OUT_RD,
    ST_OUT_CAP,
    ST_OUT_WAIT
  } sort_state_t;

endpackage

// ===== design/shaker_sort_by_key_desc.sv =====
// ----------------------------------------------------------------------------
// Descending cocktail shaker sort of keyed records
// Loads records, sorts them by key in a RAM, then streams them out.
// ----------------------------------------------------------------------------
// Records are loaded one per cycle into a single RAM of MAX_ENTRIES entries;
// a record that arrives when the store is full is dropped. The transfer
// flagged is_last ends the set: the block then stops taking input, sorts the
// n held records in place with one compare-swap per cycle (the RAM's single
// read and write port set this), and streams them out largest key first,
// equal keys in load order, with end_of_run on the final one. Each pass is
// a run of compare steps closed by an end step (ST_BEND or ST_FEND), and
// ST_BPRIME and ST_BLOAD prime the first pass; output starts in ST_OUT_RD
// and then each record is captured and offered in turn, held while out_ready
// is low. Input is taken again once the last result has been transferred.
module shaker_sort_by_key_desc #(
  parameter int MAX_ENTRIES = shkr_pkg::MAX_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  shkr_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output shkr_pkg::out_item_t out_data
);

`include "shaker_sort_by_key_desc_defines.svh"

  import shkr_pkg::*;

  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  sort_state_t state_r, state_nxt;

  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [IDX_W-1:0] lo_r, lo_nxt;
  logic [IDX_W-1:0] hi_r, hi_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] last_r, last_nxt;
  rec_t             carry_r, carry_nxt;
  rec_t             spare_r, spare_nxt;
  out_item_t        out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  rec_t             ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [REC_W-1:0] ram_rdata;
  rec_t             rd_rec;

  logic             in_xfer;
  logic             out_xfer;
  logic             store_ok;
  logic [CNT_W-1:0] count;
  logic             swap;
  rec_t             step_wdata;
  rec_t             step_carry;
  logic [IDX_W:0]   lo_inc;
  logic             bwd_done;
  logic             fwd_done;

  assign rd_rec   = rec_t'(ram_rdata);
  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  // Load bookkeeping: a record is kept only while the store has room.
  assign store_ok = (fill_r < CNT_W'(MAX_ENTRIES));
  assign count    = fill_r + CNT_W'(store_ok);

  // Compare-swap of the carried record against the one read this cycle.
  // Backward: read is the earlier entry; forward: read is the later entry.
  always_comb begin
    if (state_r == ST_BSTEP) begin
      swap = (rd_rec.key < carry_r.key);
    end else begin
      swap = (carry_r.key < rd_rec.key);
    end
    step_wdata = swap ? rd_rec : carry_r;
    step_carry = swap ? carry_r : rd_rec;
  end

  // Window bounds for the end of each pass.
  assign lo_inc   = {1'b0, lo_r} + (IDX_W+1)'(1);
  assign bwd_done = (lo_inc > {1'b0, hi_r});
  assign fwd_done = !(lo_r < hi_r);

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_xfer && in_data.is_last) begin
          state_nxt = (count == CNT_W'(1)) ? ST_OUT_RD : ST_BPRIME;
        end
      end
      ST_BPRIME:  state_nxt = ST_BLOAD;
      ST_BLOAD:   state_nxt = ST_BSTEP;
      ST_BSTEP: begin
        if (idx_r == lo_r) begin
          state_nxt = ST_BEND;
        end
      end
      ST_BEND:    state_nxt = bwd_done ? ST_OUT_RD : ST_FSTEP;
      ST_FSTEP: begin
        if (idx_r == hi_r) begin
          state_nxt = ST_FEND;
        end
      end
      ST_FEND:    state_nxt = fwd_done ? ST_OUT_RD : ST_BSTEP;
      ST_OUT_RD:  state_nxt = ST_OUT_CAP;
      ST_OUT_CAP: state_nxt = ST_OUT_WAIT;
      ST_OUT_WAIT: begin
        if (out_ready) begin
          state_nxt = (idx_r == last_r) ? ST_LOAD : ST_OUT_CAP;
        end
      end
      default:    state_nxt = ST_LOAD;
    endcase
  end

  // Output logic: handshake and RAM port control.
  always_comb begin
    in_ready  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = carry_r;
    ram_raddr = idx_r;
    unique case (state_r)
      ST_LOAD: begin
        in_ready  = 1'b1;
        ram_we    = in_xfer && store_ok;
        ram_waddr = fill_r[IDX_W-1:0];
        ram_wdata = '{key: in_data.key_value, tag: in_data.record_tag};
      end
      ST_BPRIME: ram_raddr = hi_r;
      ST_BLOAD:  ram_raddr = hi_r - IDX_W'(1);
      ST_BSTEP: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r;
        ram_wdata = step_wdata;
        ram_raddr = idx_r - IDX_W'(2);
      end
      ST_BEND: begin
        ram_we    = 1'b1;
        ram_waddr = lo_r - IDX_W'(1);
        ram_raddr = lo_inc[IDX_W-1:0];
      end
      ST_FSTEP: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r - IDX_W'(1);
        ram_wdata = step_wdata;
        ram_raddr = idx_r + IDX_W'(1);
      end
      ST_FEND: begin
        ram_we    = 1'b1;
        ram_waddr = hi_r;
        ram_raddr = hi_r - IDX_W'(2);
      end
      ST_OUT_RD:   ram_raddr = idx_r;
      ST_OUT_CAP:  ram_raddr = idx_r;
      ST_OUT_WAIT: ram_raddr = idx_r + IDX_W'(1);
      default:     ram_raddr = idx_r;
    endcase
  end

  // Datapath next values.
  always_comb begin
    fill_nxt      = fill_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    idx_nxt       = idx_r;
    last_nxt      = last_r;
    carry_nxt     = carry_r;
    spare_nxt     = spare_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    case (state_r)
      ST_LOAD: begin
        if (in_xfer) begin
          fill_nxt = count;
          if (in_data.is_last) begin
            fill_nxt = '0;
            last_nxt = IDX_W'(count - CNT_W'(1));
            hi_nxt   = IDX_W'(count - CNT_W'(1));
            lo_nxt   = IDX_W'(1);
            idx_nxt  = '0;
          end
        end
      end
      ST_BLOAD: begin
        carry_nxt = rd_rec;
        idx_nxt   = hi_r;
      end
      ST_BSTEP: begin
        carry_nxt = step_carry;
        spare_nxt = step_wdata;
        if (idx_r != lo_r) begin
          idx_nxt = idx_r - IDX_W'(1);
        end
      end
      ST_BEND: begin
        // The record left at the low end of the window seeds the forward pass.
        carry_nxt = spare_r;
        lo_nxt    = lo_inc[IDX_W-1:0];
        idx_nxt   = bwd_done ? '0 : lo_inc[IDX_W-1:0];
      end
      ST_FSTEP: begin
        carry_nxt = step_carry;
        spare_nxt = step_wdata;
        if (idx_r != hi_r) begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      ST_FEND: begin
        // The record left below the high end seeds the next backward pass.
        carry_nxt = spare_r;
        hi_nxt    = hi_r - IDX_W'(1);
        idx_nxt   = fwd_done ? '0 : hi_r - IDX_W'(1);
      end
      ST_OUT_CAP: begin
        out_nxt.sorted_key = rd_rec.key;
        out_nxt.sorted_tag = rd_rec.tag;
        out_nxt.end_of_run = (idx_r == last_r);
        out_valid_nxt      = 1'b1;
      end
      ST_OUT_WAIT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          idx_nxt       = idx_r + IDX_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and window registers.
  always_ff @(posedge clk) begin
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    idx_r   <= idx_nxt;
    last_r  <= last_nxt;
    carry_r <= carry_nxt;
    spare_r <= spare_nxt;
    out_r   <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Record store.
  shkr_ram #(
    .WIDTH (REC_W),
    .DEPTH (MAX_ENTRIES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Input and output phases never overlap.
  `SHKR_ASSERT_IMP(a_load_xor_out, clk, rst_n, in_ready, !out_valid,
                   "input accepted while a result is pending")
  // The fill count never exceeds the store capacity.
  `SHKR_ASSERT_IMP(a_fill_bound, clk, rst_n, 1'b1, fill_r <= CNT_W'(MAX_ENTRIES),
                   "fill count above capacity")
  // Compare positions stay inside the current window.
  `SHKR_ASSERT_IMP(a_step_window, clk, rst_n,
                   state_r == ST_BSTEP || state_r == ST_FSTEP,
                   idx_r >= lo_r && idx_r <= hi_r && lo_r != '0,
                   "compare position outside sort window")
  // After the final result of a run the block returns to loading.
  `SHKR_ASSERT_NXT(a_run_end, clk, rst_n, out_xfer && out_data.end_of_run,
                   in_ready && !out_valid,
                   "block did not return to loading after end of run")

endmodule

// ===== design/shkr_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module shkr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// Testbench for the descending shaker sort block
// Loads record sets over the input channel. Each set is sorted by key in the
// testbench, largest key first with equal keys kept in load order. Every
// result transfer is checked against the oldest expected record. Both
// channels idle at random.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import shkr_pkg::*;

  localparam int HOLD_MAX     = MAX_ENTRIES_DEF;
  localparam int RANDOM_ITEMS = 250;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int TAIL_CYCLES  = 200;
  localparam int REPORT_MAX   = 10;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  // Records of the set being loaded, and sorted records still to arrive.
  rec_t      held_recs[$];
  out_item_t sorted_due[$];

  int error_count = 0;
  int items_sent  = 0;
  int cycle_count = 0;
  bit gaps_on     = 1'b1;
  bit rx_lazy     = 1'b1;

  shaker_sort_by_key_desc #(
    .MAX_ENTRIES(HOLD_MAX)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial clk = 1'b0;
  always #4ns clk = ~clk;

  // Swap two neighbors when the earlier key is strictly smaller.
  function automatic void order_pair(int pos);
    rec_t tmp;
    if (held_recs[pos-1].key < held_recs[pos].key) begin
      tmp              = held_recs[pos-1];
      held_recs[pos-1] = held_recs[pos];
      held_recs[pos]   = tmp;
    end
  endfunction

  // Store an accepted record; the last one of a set sorts the set and
  // queues the sorted records as the results to come.
  function automatic void take_record(in_item_t item);
    rec_t      rec;
    out_item_t res;
    int        lo;
    int        hi;
    int        i;
    int        n;
    rec.key = item.key_value;
    rec.tag = item.record_tag;
    // A full store drops the record.
    if (held_recs.size() < HOLD_MAX) begin
      held_recs = {held_recs, rec};
    end
    if (item.is_last) begin
      n  = held_recs.size();
      lo = 1;
      hi = n - 1;
      while (lo <= hi) begin
        for (i = hi; i >= lo; i--) order_pair(i);
        lo++;
        for (i = lo; i <= hi; i++) order_pair(i);
        hi--;
      end
      for (i = 0; i < n; i++) begin
        res.sorted_key = held_recs[i].key;
        res.sorted_tag = held_recs[i].tag;
        res.end_of_run = (i == n - 1);
        sorted_due = {sorted_due, res};
      end
      held_recs.delete();
    end
  endfunction

  // Send one record and wait for its transfer. Valid stays high when the
  // next record follows without a gap.
  task automatic send_record(input logic [KEY_W-1:0] key, input logic [TAG_W-1:0] tag,
                             input logic last);
    in_item_t item;
    int       gap;
    item.key_value  = key;
    item.record_tag = tag;
    item.is_last    = last;
    gap = gaps_on ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    take_record(item);
    items_sent++;
  endtask

  // Hold off the input until every expected result has been transferred.
  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sorted_due.size() != 0) @(posedge clk);
  endtask

  // Send a set of random records with keys up to key_top; the final one
  // carries the last flag.
  task automatic send_set(input int count, input int key_top);
    int i;
    for (i = 0; i < count; i++) begin
      send_record(KEY_W'($urandom_range(0, key_top)), TAG_W'($urandom_range(0, 63)),
                  i == count - 1);
    end
  endtask

  // Single records, key and tag extremes, full reversal, ties, sorted input.
  task automatic test_directed();
    send_record(8'd255, 6'd63, 1'b1);
    send_record(8'd0, 6'd0, 1'b1);
    wait_drain();
    send_record(8'd0, 6'd1, 1'b0);
    send_record(8'd255, 6'd2, 1'b1);
    send_record(8'd7, 6'd10, 1'b0);
    send_record(8'd7, 6'd11, 1'b0);
    send_record(8'd7, 6'd12, 1'b1);
    wait_drain();
    // Ascending input needs every swap.
    send_record(8'd1, 6'd20, 1'b0);
    send_record(8'd2, 6'd21, 1'b0);
    send_record(8'd3, 6'd22, 1'b0);
    send_record(8'd4, 6'd23, 1'b0);
    send_record(8'd5, 6'd24, 1'b1);
    // Already in order, nothing moves.
    send_record(8'd200, 6'd30, 1'b0);
    send_record(8'd128, 6'd31, 1'b0);
    send_record(8'd64, 6'd32, 1'b0);
    send_record(8'd0, 6'd33, 1'b1);
    // Interleaved ties must keep their load order.
    send_record(8'd9, 6'd40, 1'b0);
    send_record(8'd200, 6'd41, 1'b0);
    send_record(8'd9, 6'd42, 1'b0);
    send_record(8'd200, 6'd43, 1'b0);
    send_record(8'd0, 6'd44, 1'b1);
    wait_drain();
  endtask

  // Exactly full store, then a set whose extra records, the last one
  // included, are dropped while the held records are still sorted.
  task automatic test_store_full();
    gaps_on = 1'b0;
    rx_lazy = 1'b1;
    send_set(HOLD_MAX, 255);
    gaps_on = 1'b1;
    send_set(HOLD_MAX + 2, 255);
    wait_drain();
  endtask

  // Random sets, mostly small, with random idling on both sides.
  task automatic test_random();
    int start;
    int size_pick;
    int count;
    int key_top;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      gaps_on   = $urandom_range(0, 2) != 0;
      rx_lazy   = $urandom_range(0, 2) != 0;
      size_pick = $urandom_range(0, 99);
      if (size_pick < 80) begin
        count = $urandom_range(1, 8);
      end else if (size_pick < 96) begin
        count = $urandom_range(9, 24);
      end else begin
        count = $urandom_range(25, HOLD_MAX);
      end
      // Narrow key ranges make plenty of ties.
      case ($urandom_range(0, 3))
        0: begin
          key_top = 3;
        end
        1: begin
          key_top = 15;
        end
        default: begin
          key_top = 255;
        end
      endcase
      send_set(count, key_top);
      if ($urandom_range(0, 7) == 0) begin
        wait_drain();
      end
    end
  endtask

  // Result side: draw a stall before each result.
  initial begin
    int stall;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      stall = rx_lazy ? $urandom_range(0, 10) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Check each result transfer against the oldest expected record.
  always @(posedge clk) begin
    out_item_t due;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (sorted_due.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_MAX) begin
          $display("Unexpected result: key %0d tag %0d end %0b", out_data.sorted_key,
                   out_data.sorted_tag, out_data.end_of_run);
        end
      end else begin
        due = sorted_due.pop_front();
        if (out_data.sorted_key !== due.sorted_key || out_data.sorted_tag !== due.sorted_tag ||
            out_data.end_of_run !== due.end_of_run) begin
          error_count++;
          if (error_count <= REPORT_MAX) begin
            $display("Result mismatch: expected key %0d tag %0d end %0b, got key %0d tag %0d end %0b",
                     due.sorted_key, due.sorted_tag, due.end_of_run, out_data.sorted_key,
                     out_data.sorted_tag, out_data.end_of_run);
          end
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Reset, then the tests in turn.
  initial begin
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_store_full();
    test_random();
    wait_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && sorted_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
